FILE: sv/manchester_word_pulse_scheduler_defines.svh
// Assertion helpers used by the scheduler RTL.
`ifndef MANCHESTER_WORD_PULSE_SCHEDULER_DEFINES_SVH
`define MANCHESTER_WORD_PULSE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, quiet while reset is low
`define MWPS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mwps: same-cycle check failed");

// Next-cycle implication, quiet while reset is low
`define MWPS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mwps: next-cycle check failed");

`endif

FILE: sv/mwps_pkg.sv
`default_nettype none

package mwps_pkg;

    localparam int unsigned DATA_W     = 16;  // data word width
    localparam int unsigned HALF_W     = 16;  // half period register width
    localparam int unsigned TICK_OUT_W = 20;  // timer value width
    localparam int unsigned WORD_BITS  = 17;  // data bits plus parity
    localparam int unsigned SEG_CAP    = 17;  // most segments in one word
    localparam int unsigned TOP_BIT    = WORD_BITS - 1;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd24;

    typedef logic [TICK_OUT_W-1:0] tick_t;

    // One result beat
    typedef struct packed {
        tick_t compare_ticks;
        tick_t period_ticks;
        logic  word_end;
        logic  frame_done;
    } seg_t;

    // Sequencer state: sync segment, bit boundary, mid bit, frame end
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYNC,
        ST_EDGE,
        ST_MID,
        ST_FRAME
    } seq_state_t;

endpackage

`default_nettype wire

FILE: sv/manchester_word_pulse_scheduler.sv
`default_nettype none

// Manchester II word scheduler. Each accepted 16-bit word (MSB first, odd
// parity appended) becomes a run of PWM segments in half-period units: a
// sync segment, then merged half-bit segments, 9 to 17 beats per word, the
// last one flagged word_end; a word marked last adds one frame_done beat with
// zero timer values. A word ending mid-level lengthens the next sync by one
// half period. The segment sequencer produces one beat per cycle unless the
// output register stalls it; the next word is taken in the cycle its
// predecessor's final beat enters the output register. half_period must be
// written only while the block is idle (not enforced by the block), and then
// takes effect on the next word; only its low TICK_WIDTH bits are used.
module manchester_word_pulse_scheduler
    import mwps_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [HALF_W-1:0]     cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_data_word,
    input  logic                  s_last_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TICK_OUT_W-1:0] m_compare_ticks,
    output logic [TICK_OUT_W-1:0] m_period_ticks,
    output logic                  m_word_end,
    output logic                  m_frame_done
);

    localparam int unsigned HP_W = (TICK_WIDTH < HALF_W) ? TICK_WIDTH : HALF_W;

    logic [HALF_W-1:0] half_period_reg;
    tick_t             hp;
    logic              seg_valid, seg_ready;
    seg_t              seg, out_seg;

    // half period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    assign hp = tick_t'(half_period_reg[HP_W-1:0]);

    mwps_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hp        (hp),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data_word),
        .in_last   (s_last_word),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_ready (seg_ready)
    );

    mwps_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (seg_valid),
        .in_ready (seg_ready),
        .in_seg   (seg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_seg    (out_seg)
    );

    assign m_compare_ticks = out_seg.compare_ticks;
    assign m_period_ticks  = out_seg.period_ticks;
    assign m_word_end      = out_seg.word_end;
    assign m_frame_done    = out_seg.frame_done;

endmodule

`default_nettype wire

FILE: sv/mwps_seq.sv
`default_nettype none

`include "manchester_word_pulse_scheduler_defines.svh"

module mwps_seq
    import mwps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tick_t             hp,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    input  logic              in_last,
    output logic              seg_valid,
    output seg_t              seg,
    input  logic              seg_ready
);

    localparam int unsigned CNT_W  = $clog2(SEG_CAP + 1);
    localparam int unsigned LEFT_W = $clog2(WORD_BITS + 1);

    seq_state_t              state_reg, state_next;
    logic [WORD_BITS-1:0]    shifter_reg, shifter_next;
    logic [LEFT_W-1:0]       left_reg, left_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ext_reg, ext_next;
    logic                    last_reg, last_next;

    // step decode
    logic [3:0]              cmp_f, per_f;
    logic                    word_done;
    logic [1:0]              shift_n;
    logic                    ext_wr, ext_val;
    logic                    seg_fd;
    seq_state_t              loop_state;

    logic [LEFT_W-1:0]       left_m1, left_m2;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    in_loop, loop_over, step, closing, in_fire;

    // hp times a small factor, shifts and adds
    function automatic tick_t mul_hp(tick_t h, logic [3:0] f);
        tick_t acc;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            if (f[i]) begin
                acc = acc + (h << i);
            end
        end
        return acc;
    endfunction

    // saturating bit counts after one and two shifts
    assign left_m1 = (left_reg == '0) ? '0 : left_reg - LEFT_W'(1);
    assign left_m2 = (left_m1 == '0) ? '0 : left_m1 - LEFT_W'(1);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    // segment decode for the current state
    always_comb begin
        cmp_f      = 4'd0;
        per_f      = 4'd0;
        word_done  = 1'b0;
        shift_n    = 2'd0;
        ext_wr     = 1'b0;
        ext_val    = 1'b0;
        seg_fd     = 1'b0;
        loop_state = state_reg;
        unique case (state_reg)
            ST_SYNC: begin
                // sync merged with first half of the first bit
                cmp_f      = ext_reg ? 4'd4 : 4'd3;
                per_f      = (shifter_reg[TOP_BIT] ? 4'd7 : 4'd6) + {3'd0, ext_reg};
                shift_n    = 2'd1;
                loop_state = shifter_reg[TOP_BIT] ? ST_MID : ST_EDGE;
            end
            ST_EDGE: begin
                cmp_f = 4'd1;
                if (left_reg == '0) begin
                    // trailing boundary closer
                    per_f     = 4'd2;
                    ext_wr    = 1'b1;
                    ext_val   = 1'b0;
                    word_done = 1'b1;
                end else if (shifter_reg[TOP_BIT]) begin
                    per_f   = 4'd3;
                    shift_n = 2'd1;
                    if (left_reg == LEFT_W'(1)) begin
                        ext_wr    = 1'b1;
                        ext_val   = 1'b1;
                        word_done = 1'b1;
                    end else begin
                        loop_state = ST_MID;
                    end
                end else begin
                    per_f   = 4'd2;
                    shift_n = 2'd1;
                end
            end
            ST_MID: begin
                if (shifter_reg[TOP_BIT]) begin
                    cmp_f   = 4'd1;
                    per_f   = 4'd2;
                    shift_n = 2'd1;
                    if (left_m1 == '0) begin
                        ext_wr    = 1'b1;
                        ext_val   = 1'b1;
                        word_done = 1'b1;
                    end
                end else begin
                    cmp_f   = 4'd2;
                    shift_n = 2'd2;
                    if (shifter_reg[TOP_BIT-1]) begin
                        per_f = 4'd4;
                        if (left_m1 == LEFT_W'(1)) begin
                            ext_wr    = 1'b1;
                            ext_val   = 1'b1;
                            word_done = 1'b1;
                        end
                    end else begin
                        per_f = 4'd3;
                        if (left_m1 == '0) begin
                            ext_wr    = 1'b1;
                            ext_val   = 1'b0;
                            word_done = 1'b1;
                        end else begin
                            loop_state = ST_EDGE;
                        end
                    end
                end
            end
            ST_FRAME: begin
                // frame end beat, carry cleared
                seg_fd  = 1'b1;
                ext_wr  = 1'b1;
                ext_val = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign seg_valid          = (state_reg != ST_IDLE);
    assign seg.compare_ticks  = mul_hp(hp, cmp_f);
    assign seg.period_ticks   = mul_hp(hp, per_f);
    assign seg.word_end       = word_done;
    assign seg.frame_done     = seg_fd;

    // handshake: take a word when idle or as the last beat leaves
    assign step      = seg_valid && seg_ready;
    assign in_loop   = (state_reg == ST_SYNC) || (state_reg == ST_EDGE) ||
                       (state_reg == ST_MID);
    assign loop_over = word_done || (cnt_inc == CNT_W'(SEG_CAP));
    assign closing   = step && ((state_reg == ST_FRAME) || (in_loop && loop_over && !last_reg));
    assign in_ready  = (state_reg == ST_IDLE) || closing;
    assign in_fire   = in_valid && in_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        if (step) begin
            if (state_reg == ST_FRAME) begin
                state_next = ST_IDLE;
            end else if (in_loop) begin
                if (loop_over) begin
                    state_next = last_reg ? ST_FRAME : ST_IDLE;
                end else begin
                    state_next = loop_state;
                end
            end
        end
        if (in_fire) begin
            state_next = ST_SYNC;
        end
    end

    // word datapath
    always_comb begin
        shifter_next = shifter_reg;
        left_next    = left_reg;
        cnt_next     = cnt_reg;
        ext_next     = ext_reg;
        last_next    = last_reg;
        if (step) begin
            shifter_next = shifter_reg << shift_n;
            unique case (shift_n)
                2'd0:    left_next = left_reg;
                2'd1:    left_next = left_m1;
                default: left_next = left_m2;
            endcase
            cnt_next = cnt_inc;
            if (ext_wr) begin
                ext_next = ext_val;
            end
        end
        if (in_fire) begin
            // data MSB first, odd parity last
            shifter_next = {in_data, ~^in_data};
            left_next    = LEFT_W'(WORD_BITS);
            cnt_next     = '0;
            last_next    = in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            cnt_reg   <= '0;
            ext_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            ext_reg   <= ext_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        shifter_reg <= shifter_next;
    end

    // checks
    `MWPS_ASSERT_NEXT(a_load_sync, aclk, aresetn, in_fire, (state_reg == ST_SYNC) && (left_reg == LEFT_W'(WORD_BITS)) && (cnt_reg == '0))
    `MWPS_ASSERT_IMPL(a_seg_cap, aclk, aresetn, (state_reg == ST_EDGE) || (state_reg == ST_MID), (cnt_reg != '0) && (cnt_reg < CNT_W'(SEG_CAP)))
    `MWPS_ASSERT_NEXT(a_carry_hold, aclk, aresetn, !step, $stable(ext_reg))
    `MWPS_ASSERT_IMPL(a_frame_last, aclk, aresetn, state_reg == ST_FRAME, last_reg)

endmodule

`default_nettype wire

FILE: sv/mwps_out_stage.sv
`default_nettype none

module mwps_out_stage
    import mwps_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  seg_t in_seg,
    output logic m_valid,
    input  logic m_ready,
    output seg_t m_seg
);

    logic full_reg, full_next;
    seg_t data_reg;
    logic load;

    // one-deep result register, refilled as it drains
    assign in_ready  = !full_reg || m_ready;
    assign load      = in_valid && in_ready;
    assign full_next = load || (full_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= in_seg;
        end
    end

    assign m_valid = full_reg;
    assign m_seg   = data_reg;

endmodule

`default_nettype wire

FILE: sim/mwps_tb_pkg.sv
package mwps_tb_pkg;
    import mwps_pkg::*;

    // Predicts the Manchester segment schedule of each accepted word and
    // checks result beats against it in order.
    class seg_schedule_checker;
        logic [HALF_W-1:0]    half_period;
        logic [31:0]          tick_mask;
        logic                 carry_sync;    // next sync gets one more half period
        logic [WORD_BITS-1:0] pend_bits;     // data + parity, next bit on top
        int unsigned          bits_left;
        seg_t                 segs_due[$];
        int unsigned          mismatches;

        function new(int unsigned tick_w);
            half_period = HALF_PERIOD_RESET;
            tick_mask   = (tick_w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << tick_w) - 32'd1);
            carry_sync  = 1'b0;
            pend_bits   = '0;
            bits_left   = 0;
            mismatches  = 0;
        endfunction

        function void set_half_period(logic [HALF_W-1:0] hp);
            half_period = hp;
        endfunction

        function int unsigned pending();
            return segs_due.size();
        endfunction

        // consume one bit of the word
        function void step_bit();
            pend_bits = pend_bits << 1;
            if (bits_left > 0) begin
                bits_left--;
            end
        endfunction

        function void push_seg(tick_t cmp, tick_t per, logic w_end, logic f_done);
            segs_due.push_back('{compare_ticks: cmp, period_ticks: per,
                                 word_end: w_end, frame_done: f_done});
        endfunction

        // Expand one accepted beat into the segments it produces
        function void note_word(logic [DATA_W-1:0] word, logic last);
            seq_state_t  ph;
            tick_t       hp;
            tick_t       pad;
            tick_t       cmp;
            tick_t       per;
            bit          done;
            int unsigned n;

            hp  = tick_t'(32'(half_period) & tick_mask);
            pad = carry_sync ? hp : '0;
            pend_bits = {word, ~^word};   // odd parity appended
            bits_left = WORD_BITS;

            // sync, merged with the first half of bit 15
            cmp = tick_t'(3 * hp + pad);
            if (pend_bits[TOP_BIT]) begin
                per = tick_t'(7 * hp + pad);
                ph  = ST_MID;
            end else begin
                per = tick_t'(6 * hp + pad);
                ph  = ST_EDGE;
            end
            step_bit();
            push_seg(cmp, per, 1'b0, 1'b0);
            n    = 1;
            done = 0;

            // merged half-bit segments
            while (!done && n < SEG_CAP) begin
                if (ph == ST_EDGE) begin
                    cmp = hp;
                    if (bits_left == 0) begin
                        // trailing boundary: closing segment
                        per = tick_t'(2 * hp);
                        carry_sync = 1'b0;
                        done = 1;
                    end else if (pend_bits[TOP_BIT]) begin
                        per = tick_t'(3 * hp);
                        if (bits_left == 1) begin
                            carry_sync = 1'b1;
                            done = 1;
                        end else begin
                            ph = ST_MID;
                        end
                        step_bit();
                    end else begin
                        per = tick_t'(2 * hp);
                        step_bit();
                    end
                end else begin
                    if (pend_bits[TOP_BIT]) begin
                        cmp = hp;
                        per = tick_t'(2 * hp);
                        step_bit();
                        if (bits_left == 0) begin
                            carry_sync = 1'b1;
                            done = 1;
                        end
                    end else begin
                        step_bit();
                        cmp = tick_t'(2 * hp);
                        if (pend_bits[TOP_BIT]) begin
                            per = tick_t'(4 * hp);
                            if (bits_left == 1) begin
                                carry_sync = 1'b1;
                                done = 1;
                            end
                        end else begin
                            per = tick_t'(3 * hp);
                            if (bits_left == 0) begin
                                carry_sync = 1'b0;
                                done = 1;
                            end else begin
                                ph = ST_EDGE;
                            end
                        end
                        step_bit();
                    end
                end
                push_seg(cmp, per, logic'(done), 1'b0);
                n++;
            end

            // frame end clears the carried sync extension
            if (last) begin
                push_seg('0, '0, 1'b0, 1'b1);
                carry_sync = 1'b0;
                pend_bits  = '0;
                bits_left  = 0;
            end
        endfunction

        // Compare one result beat with the oldest predicted segment
        function void check_segment(seg_t got);
            seg_t want;
            if (segs_due.size() == 0) begin
                $error("unexpected beat: compare_ticks %0d period_ticks %0d word_end %0b frame_done %0b",
                       got.compare_ticks, got.period_ticks, got.word_end, got.frame_done);
                mismatches++;
                return;
            end
            want = segs_due.pop_front();
            if (got.compare_ticks !== want.compare_ticks) begin
                $error("compare_ticks: expected %0d, actual %0d",
                       want.compare_ticks, got.compare_ticks);
                mismatches++;
            end
            if (got.period_ticks !== want.period_ticks) begin
                $error("period_ticks: expected %0d, actual %0d",
                       want.period_ticks, got.period_ticks);
                mismatches++;
            end
            if (got.word_end !== want.word_end) begin
                $error("word_end: expected %0b, actual %0b", want.word_end, got.word_end);
                mismatches++;
            end
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done: expected %0b, actual %0b",
                       want.frame_done, got.frame_done);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mwps_pkg::*;
    import mwps_tb_pkg::*;

    localparam int unsigned TICK_W        = 16;
    localparam int unsigned CYCLE_LIMIT   = 500_000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_WORDS   = 80;
    localparam int unsigned DIR_COUNT     = 22;

    // Directed words: extremes, alternations, long runs, frame ends
    localparam logic [DATA_W-1:0] DIR_WORDS [DIR_COUNT] = '{
        16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555,
        16'h7FFF, 16'hFFFE, 16'h0003, 16'hC000, 16'h0000, 16'hFFFF,
        16'h1234, 16'hFEDC, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0,
        16'h0001, 16'h8000, 16'hCCCC, 16'h3333
    };
    localparam bit DIR_LAST [DIR_COUNT] = '{
        0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 1, 1,
        0, 0, 0, 1, 0, 0,
        0, 1, 0, 1
    };

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [HALF_W-1:0]     cfg_wr_data     = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_word     = '0;
    logic                  s_last_word     = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [TICK_OUT_W-1:0] m_compare_ticks;
    logic [TICK_OUT_W-1:0] m_period_ticks;
    logic                  m_word_end;
    logic                  m_frame_done;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned words_sent   = 0;
    int unsigned beats_seen   = 0;
    int unsigned frames_seen  = 0;
    int unsigned hp_settings  = 1;

    seg_schedule_checker sched = new(TICK_W);

    manchester_word_pulse_scheduler #(
        .TICK_WIDTH (TICK_W)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_word     (s_data_word),
        .s_last_word     (s_last_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_compare_ticks (m_compare_ticks),
        .m_period_ticks  (m_period_ticks),
        .m_word_end      (m_word_end),
        .m_frame_done    (m_frame_done)
    );

    always #10 aclk = ~aclk;

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // result beats
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (m_frame_done) begin
                frames_seen++;
            end
            sched.check_segment(seg_t'({m_compare_ticks, m_period_ticks,
                                        m_word_end, m_frame_done}));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one word beat, with random idle cycles ahead of it
    task automatic send_word(input logic [DATA_W-1:0] word, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid     <= 1'b0;
            s_data_word <= DATA_W'($urandom);
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_word <= word;
        s_last_word <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sched.note_word(word, last);
        words_sent++;
    endtask

    // Stop sending and wait for every predicted segment to come out
    task automatic drain_segments();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sched.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_half_period(input logic [HALF_W-1:0] hp);
        drain_segments();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hp;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sched.set_half_period(hp);
        hp_settings++;
    endtask

    initial begin
        logic [HALF_W-1:0] hp;
        logic [DATA_W-1:0] word;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at the reset half period
        snd_idle_pct = 28;
        rcv_idle_pct = 85;
        for (int i = 0; i < DIR_COUNT; i++) begin
            send_word(DIR_WORDS[i], DIR_LAST[i]);
        end

        // random phases, each with its own half period
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       hp = 16'd1;
                2:       hp = 16'hFFFF;
                4:       hp = 16'd2;
                default: hp = HALF_W'($urandom_range(65535, 1));
            endcase
            write_half_period(hp);
            snd_idle_pct = (p < 2) ? 28 : (p < 4) ? 85 : 0;
            rcv_idle_pct = (p < 2) ? 85 : (p < 4) ? 28 : 0;

            for (int i = 0; i < PHASE_WORDS; i++) begin
                // pause mid-phase until the schedule is fully drained
                if (i == PHASE_WORDS / 2) begin
                    drain_segments();
                end
                case ($urandom_range(3))
                    0: word = DATA_W'($urandom);
                    1: word = {DATA_W{1'($urandom_range(1))}} ^
                              (DATA_W'(1) << $urandom_range(DATA_W - 1));
                    2: word = ($urandom_range(1) ? 16'hAAAA : 16'h5555) ^
                              DATA_W'($urandom & $urandom & $urandom);
                    default: word = $urandom_range(1) ? DATA_W'($urandom & $urandom)
                                                      : DATA_W'($urandom | $urandom);
                endcase
                send_word(word, $urandom_range(5) == 0);
            end
        end

        drain_segments();
        $display("Sent %0d words, checked %0d segment beats including %0d frame ends,",
                 words_sent, beats_seen, frames_seen);
        $display("over %0d half period settings from 1 to 65535 and three idling mixes.",
                 hp_settings);
        if (sched.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
